// ----- rtl/core/wtrc_pkg.sv -----
// Shared types, widths and reset constants of the weighted thermostat relay control.
package wtrc_pkg;

  // Field widths.
  localparam int TIME_W  = 32;
  localparam int TEMP_W  = 12;
  localparam int THR_W   = 8;
  localparam int SEC_W   = 16;
  localparam int WGT_W   = 64;
  localparam int BYTE_W  = 8;
  localparam int CNT_W   = 4;
  localparam int TEMPS   = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 64;

  // Internal datapath widths: weighted sums and their magnitudes.
  localparam int ACC_W   = 25;
  localparam int WSUM_W  = 12;
  localparam int MAG_W   = ACC_W - 1;
  localparam int REM_W   = WSUM_W + 1;
  localparam int DIV_CNT_W = 5;

  // Register reset values.
  localparam logic signed [THR_W-1:0] LOW_THR_RST  = 8'sd3;
  localparam logic signed [THR_W-1:0] HIGH_THR_RST = 8'sd10;
  localparam logic [SEC_W-1:0]        MIN_ON_RST   = 16'd10;
  localparam logic [SEC_W-1:0]        MIN_OFF_RST  = 16'd10;
  localparam logic [WGT_W-1:0]        WEIGHTS_RST  = 64'h0C0C_0C0C_0C0C_0C0C;
  localparam logic [CNT_W-1:0]        COUNT_RST    = 4'd8;

  // Average reported when all weights are zero (-127 degrees).
  localparam logic signed [TEMP_W-1:0] NO_WEIGHT_AVG = -12'sd2032;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW_THR   = 3'd0,
    REG_HIGH_THR  = 3'd1,
    REG_MIN_ON    = 3'd2,
    REG_MIN_OFF   = 3'd3,
    REG_WEIGHTS   = 3'd4,
    REG_COUNT     = 3'd5
  } cfg_reg_e;

  // Relay action codes.
  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_OFF  = 2'd1,
    ACT_ON   = 2'd2
  } action_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_PREP,
    S_DIV,
    S_DECIDE
  } state_e;

endpackage

// ----- rtl/core/weighted_thermostat_relay_control.sv -----
// Weighted-average thermostat with hysteresis, dwell times and bit-serial arithmetic.
//
// Channel   Direction  Handshake                 Payload
// in        sink       in_valid_i / in_stall_o   now_seconds_i, temp_0_i .. temp_7_i
// out       source     out_valid_o / out_stall_i relay_state_o, action_o, average_temp_o,
//                                                sensor_fault_o
// cfg       sink       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// A scan runs from acceptance to the result register through the sequencer states: a
// weight-bit-serial multiply and accumulate over the eight weight bits of each of the n
// clamped sensors, flag forming, restoring division, and a decision state that waits
// for the output register to be free. The next scan is taken once the sequencer is back in
// idle, even while the previous result still waits in the output register. Reset clears
// the relay, the dwell time stamp and the registers to their defaults.
module weighted_thermostat_relay_control #(
  parameter int SENSORS = 8
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Scan requests.
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [wtrc_pkg::TIME_W-1:0]            now_seconds_i,
  input  logic signed [wtrc_pkg::TEMP_W-1:0]     temp_0_i,
  input  logic signed [wtrc_pkg::TEMP_W-1:0]     temp_1_i,
  input  logic signed [wtrc_pkg::TEMP_W-1:0]     temp_2_i,
  input  logic signed [wtrc_pkg::TEMP_W-1:0]     temp_3_i,
  input  logic signed [wtrc_pkg::TEMP_W-1:0]     temp_4_i,
  input  logic signed [wtrc_pkg::TEMP_W-1:0]     temp_5_i,
  input  logic signed [wtrc_pkg::TEMP_W-1:0]     temp_6_i,
  input  logic signed [wtrc_pkg::TEMP_W-1:0]     temp_7_i,
  // Results.
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic                                   relay_state_o,
  output logic [1:0]                             action_o,
  output logic signed [wtrc_pkg::TEMP_W-1:0]     average_temp_o,
  output logic                                   sensor_fault_o,
  // Configuration writes.
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [wtrc_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [wtrc_pkg::CFG_DAT_W-1:0]         cfg_data_i
);
  import wtrc_pkg::*;

  // Number of sensors that can take part at all.
  localparam int N_MAX = (SENSORS < TEMPS) ? SENSORS : TEMPS;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(MAG_W - 1);

  // Configuration registers.
  logic signed [THR_W-1:0] low_thr_q, high_thr_q;
  logic [SEC_W-1:0]        min_on_q, min_off_q;
  logic [WGT_W-1:0]        weights_q;
  logic [CNT_W-1:0]        count_q;

  // Control state.
  state_e                  state_q, state_d;
  logic                    relay_on_q, relay_on_d;
  logic [TIME_W-1:0]       switched_at_q, switched_at_d;
  logic                    out_valid_q, out_valid_d;

  // Scan payload and serial datapath.
  logic [TIME_W-1:0]              now_q, now_d;
  logic signed [TEMP_W-1:0]       temp_q [TEMPS];
  logic signed [TEMP_W-1:0]       temp_d [TEMPS];
  logic [WGT_W-1:0]               wsh_q, wsh_d;
  logic signed [ACC_W-1:0]        mc_q, mc_d, hm_q, hm_d, lm_q, lm_d;
  logic signed [ACC_W-1:0]        s_acc_q, s_acc_d, h_acc_q, h_acc_d, l_acc_q, l_acc_d;
  logic [WSUM_W-1:0]              w_q, w_d;
  logic [2:0]                     sens_q, sens_d;
  logic [2:0]                     bit_q, bit_d;
  logic [MAG_W-1:0]               dvd_q, dvd_d;
  logic [REM_W-1:0]               rem_q, rem_d;
  logic [DIV_CNT_W-1:0]           div_cnt_q, div_cnt_d;
  logic                           sneg_q, sneg_d;
  logic                           wzero_q, wzero_d;
  logic                           fault_q, fault_d;
  logic                           can_on_q, can_on_d;
  logic                           ge_hi_q, ge_hi_d;
  logic                           le_lo_q, le_lo_d;

  // Result register.
  logic                           relay_out_q, relay_out_d;
  action_e                        action_q, action_d;
  logic signed [TEMP_W-1:0]       avg_q, avg_d;
  logic                           fault_out_q, fault_out_d;

  // Handshake terms.
  logic              in_take;
  logic              out_take;
  logic              out_free;
  logic [CNT_W-1:0]  n_eff;
  logic [2:0]        sens_last;

  assign in_take  = in_valid_i && !in_stall_o;
  assign out_take = out_valid_q && !out_stall_i;
  assign out_free = !out_valid_q || !out_stall_i;

  // Sensor count limited to the available inputs.
  assign n_eff     = (count_q > CNT_W'(N_MAX)) ? CNT_W'(N_MAX) : count_q;
  assign sens_last = 3'(n_eff - CNT_W'(1));

  // Configuration write decoder; the port never refuses a request.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_thr_q  <= LOW_THR_RST;
      high_thr_q <= HIGH_THR_RST;
      min_on_q   <= MIN_ON_RST;
      min_off_q  <= MIN_OFF_RST;
      weights_q  <= WEIGHTS_RST;
      count_q    <= COUNT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_LOW_THR:  low_thr_q  <= cfg_data_i[THR_W-1:0];
        REG_HIGH_THR: high_thr_q <= cfg_data_i[THR_W-1:0];
        REG_MIN_ON:   min_on_q   <= cfg_data_i[SEC_W-1:0];
        REG_MIN_OFF:  min_off_q  <= cfg_data_i[SEC_W-1:0];
        REG_WEIGHTS:  weights_q  <= cfg_data_i[WGT_W-1:0];
        REG_COUNT:    count_q    <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_take) begin
          state_d = (n_eff == '0) ? S_PREP : S_MAC;
        end
      end
      S_MAC: begin
        if (bit_q == 3'd7 && sens_q == sens_last) begin
          state_d = S_PREP;
        end
      end
      S_PREP: state_d = S_DIV;
      S_DIV: begin
        if (div_cnt_q == DIV_LAST) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall_o = (state_q != S_IDLE);
  end

  // Datapath: serial multiply-accumulate, flag forming, division and relay decision.
  always_comb begin
    logic [REM_W-1:0]        trial;
    logic signed [ACC_W-1:0] fsum;
    logic [ACC_W-1:0]        flim;
    logic [ACC_W-1:0]        smag;
    logic [TIME_W-1:0]       elapsed;
    logic [TEMP_W-1:0]       quot;

    now_d         = now_q;
    temp_d        = temp_q;
    wsh_d         = wsh_q;
    mc_d          = mc_q;
    hm_d          = hm_q;
    lm_d          = lm_q;
    s_acc_d       = s_acc_q;
    h_acc_d       = h_acc_q;
    l_acc_d       = l_acc_q;
    w_d           = w_q;
    sens_d        = sens_q;
    bit_d         = bit_q;
    dvd_d         = dvd_q;
    rem_d         = rem_q;
    div_cnt_d     = div_cnt_q;
    sneg_d        = sneg_q;
    wzero_d       = wzero_q;
    fault_d       = fault_q;
    can_on_d      = can_on_q;
    ge_hi_d       = ge_hi_q;
    le_lo_d       = le_lo_q;
    relay_on_d    = relay_on_q;
    switched_at_d = switched_at_q;
    relay_out_d   = relay_out_q;
    action_d      = action_q;
    avg_d         = avg_q;
    fault_out_d   = fault_out_q;
    out_valid_d   = out_take ? 1'b0 : out_valid_q;

    trial   = {rem_q[REM_W-2:0], dvd_q[MAG_W-1]};
    flim    = ACC_W'({w_q, 10'b0}) + ACC_W'({w_q, 9'b0}) + ACC_W'({w_q, 6'b0});
    fsum    = s_acc_q + $signed(flim);
    smag    = s_acc_q[ACC_W-1] ? ACC_W'(-s_acc_q) : ACC_W'(s_acc_q);
    elapsed = now_q - switched_at_q;
    quot    = dvd_q[TEMP_W-1:0];

    case (state_q)
      // Load the scan and the first sensor's operands.
      S_IDLE: begin
        if (in_take) begin
          now_d     = now_seconds_i;
          temp_d[0] = temp_0_i;
          temp_d[1] = temp_1_i;
          temp_d[2] = temp_2_i;
          temp_d[3] = temp_3_i;
          temp_d[4] = temp_4_i;
          temp_d[5] = temp_5_i;
          temp_d[6] = temp_6_i;
          temp_d[7] = temp_7_i;
          mc_d      = {{(ACC_W-TEMP_W){temp_0_i[TEMP_W-1]}}, temp_0_i};
          hm_d      = {{(ACC_W-THR_W){high_thr_q[THR_W-1]}}, high_thr_q} <<< 4;
          lm_d      = {{(ACC_W-THR_W){low_thr_q[THR_W-1]}}, low_thr_q} <<< 4;
          s_acc_d   = '0;
          h_acc_d   = '0;
          l_acc_d   = '0;
          w_d       = (n_eff == '0) ? '0 : WSUM_W'(weights_q[BYTE_W-1:0]);
          wsh_d     = weights_q;
          sens_d    = '0;
          bit_d     = '0;
        end
      end
      // One weight bit per cycle: add the shifted temperature and threshold terms.
      S_MAC: begin
        if (wsh_q[0]) begin
          s_acc_d = s_acc_q + mc_q;
          h_acc_d = h_acc_q + hm_q;
          l_acc_d = l_acc_q + lm_q;
        end
        wsh_d = wsh_q >> 1;
        bit_d = bit_q + 3'd1;
        if (bit_q == 3'd7) begin
          // Move on to the next sensor.
          sens_d = sens_q + 3'd1;
          for (int k = 0; k < TEMPS - 1; k++) begin
            temp_d[k] = temp_q[k+1];
          end
          mc_d = {{(ACC_W-TEMP_W){temp_q[1][TEMP_W-1]}}, temp_q[1]};
          hm_d = {{(ACC_W-THR_W){high_thr_q[THR_W-1]}}, high_thr_q} <<< 4;
          lm_d = {{(ACC_W-THR_W){low_thr_q[THR_W-1]}}, low_thr_q} <<< 4;
          if (sens_q != sens_last) begin
            w_d = w_q + WSUM_W'(wsh_q[BYTE_W:1]);
          end
        end else begin
          mc_d = mc_q <<< 1;
          hm_d = hm_q <<< 1;
          lm_d = lm_q <<< 1;
        end
      end
      // Decision flags compare exact products; load the divider with |S|.
      S_PREP: begin
        wzero_d   = (w_q == '0);
        fault_d   = (w_q == '0) || (fsum < 0);
        can_on_d  = (w_q != '0) && (fsum > 0);
        ge_hi_d   = (s_acc_q >= h_acc_q);
        le_lo_d   = (s_acc_q <= l_acc_q);
        sneg_d    = s_acc_q[ACC_W-1];
        dvd_d     = smag[MAG_W-1:0];
        rem_d     = '0;
        div_cnt_d = '0;
      end
      // Restoring division, one quotient bit per cycle.
      S_DIV: begin
        if (trial >= {1'b0, w_q}) begin
          rem_d = trial - {1'b0, w_q};
          dvd_d = {dvd_q[MAG_W-2:0], 1'b1};
        end else begin
          rem_d = trial;
          dvd_d = {dvd_q[MAG_W-2:0], 1'b0};
        end
        div_cnt_d = div_cnt_q + DIV_CNT_W'(1);
      end
      // Hysteresis with dwell times; a fault always commands the relay off.
      S_DECIDE: begin
        if (out_free) begin
          action_d = ACT_NONE;
          if (fault_q || (relay_on_q && ge_hi_q && !wzero_q &&
                          elapsed >= TIME_W'(min_on_q))) begin
            relay_on_d    = 1'b0;
            switched_at_d = now_q;
            action_d      = ACT_OFF;
          end else if (can_on_q && le_lo_q && !relay_on_q &&
                       elapsed >= TIME_W'(min_off_q)) begin
            relay_on_d    = 1'b1;
            switched_at_d = now_q;
            action_d      = ACT_ON;
          end
          relay_out_d = relay_on_d;
          fault_out_d = fault_q;
          if (wzero_q) begin
            avg_d = NO_WEIGHT_AVG;
          end else begin
            avg_d = sneg_q ? $signed(TEMP_W'(-quot)) : $signed(quot);
          end
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      relay_on_q    <= 1'b0;
      switched_at_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      relay_on_q    <= relay_on_d;
      switched_at_q <= switched_at_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    now_q       <= now_d;
    temp_q      <= temp_d;
    wsh_q       <= wsh_d;
    mc_q        <= mc_d;
    hm_q        <= hm_d;
    lm_q        <= lm_d;
    s_acc_q     <= s_acc_d;
    h_acc_q     <= h_acc_d;
    l_acc_q     <= l_acc_d;
    w_q         <= w_d;
    sens_q      <= sens_d;
    bit_q       <= bit_d;
    dvd_q       <= dvd_d;
    rem_q       <= rem_d;
    div_cnt_q   <= div_cnt_d;
    sneg_q      <= sneg_d;
    wzero_q     <= wzero_d;
    fault_q     <= fault_d;
    can_on_q    <= can_on_d;
    ge_hi_q     <= ge_hi_d;
    le_lo_q     <= le_lo_d;
    relay_out_q <= relay_out_d;
    action_q    <= action_d;
    avg_q       <= avg_d;
    fault_out_q <= fault_out_d;
  end

  // Result ports.
  assign out_valid_o    = out_valid_q;
  assign relay_state_o  = relay_out_q;
  assign action_o       = action_q;
  assign average_temp_o = avg_q;
  assign sensor_fault_o = fault_out_q;

  // A faulty scan never leaves the relay on.
  a_fault_relay_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sensor_fault_o |-> !relay_state_o)
    else $error("relay reported on with a sensor fault");

  // The reported action agrees with the reported relay drive.
  a_action_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (action_o == ACT_ON || action_o == ACT_OFF) |->
      (relay_state_o == (action_o == ACT_ON)))
    else $error("action disagrees with relay state");

  // An accepted scan starts the arithmetic right away.
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> (state_q == S_MAC || state_q == S_PREP))
    else $error("accepted scan did not start");

endmodule

// ----- tb/tb_weighted_thermostat_relay_control.sv -----
// Self-checking testbench for the weighted thermostat relay control block.
module tb_weighted_thermostat_relay_control;
  timeunit 1ns;
  timeprecision 1ps;

  import wtrc_pkg::*;

  localparam int     WATCHDOG_LIMIT  = 4000;
  localparam int     HOLD_OFF_CYCLES = 800;
  localparam int     DRAIN_CYCLES    = 100;
  localparam int     MAX_REPORTS     = 10;
  localparam int     RANDOM_PHASES   = 7;
  localparam int     PHASE_SCANS     = 220;
  localparam longint FAULT_SIXTEENTHS = -1600;

  // One scan request: time stamp and the eight sensor readings.
  typedef struct packed {
    logic [TIME_W-1:0]             stamp;
    logic [TEMPS-1:0][TEMP_W-1:0]  temps;
  } scan_t;

  // One result of the relay decision.
  typedef struct {
    logic                     relay;
    action_e                  action;
    logic signed [TEMP_W-1:0] average;
    logic                     fault;
  } relay_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                         in_valid = 1'b0;
  logic                         in_stall_o;
  logic [TIME_W-1:0]            stamp_drv = '0;
  logic [TEMPS-1:0][TEMP_W-1:0] temps_drv = '0;

  logic                     out_valid_o;
  logic                     out_stall = 1'b1;
  logic                     relay_state_o;
  logic [1:0]               action_o;
  logic signed [TEMP_W-1:0] average_temp_o;
  logic                     sensor_fault_o;

  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index = REG_LOW_THR;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  // Traffic shaping and bookkeeping.
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic hold_off = 1'b0;
  int   quiet_cycles = 0;
  int   scans_accepted = 0;
  int   results_seen = 0;
  int   mismatches = 0;
  int   settings_used = 1;
  int   relay_ons = 0;
  int   relay_offs = 0;
  int   faults_seen = 0;
  logic [TIME_W-1:0] scan_clock = '0;

  scan_t         pending_scans[$];
  scan_t         offered_scan;
  relay_result_t awaited_results[$];

  // Shadow copy of the registers and of the relay state.
  logic signed [THR_W-1:0] cfg_low_thr  = LOW_THR_RST;
  logic signed [THR_W-1:0] cfg_high_thr = HIGH_THR_RST;
  logic [SEC_W-1:0]        cfg_min_on   = MIN_ON_RST;
  logic [SEC_W-1:0]        cfg_min_off  = MIN_OFF_RST;
  logic [WGT_W-1:0]        cfg_weights  = WEIGHTS_RST;
  logic [CNT_W-1:0]        cfg_count    = COUNT_RST;
  logic                    relay_is_on  = 1'b0;
  logic [TIME_W-1:0]       last_switch  = '0;

  weighted_thermostat_relay_control u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .now_seconds_i  (stamp_drv),
    .temp_0_i       (temps_drv[0]),
    .temp_1_i       (temps_drv[1]),
    .temp_2_i       (temps_drv[2]),
    .temp_3_i       (temps_drv[3]),
    .temp_4_i       (temps_drv[4]),
    .temp_5_i       (temps_drv[5]),
    .temp_6_i       (temps_drv[6]),
    .temp_7_i       (temps_drv[7]),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .relay_state_o  (relay_state_o),
    .action_o       (action_o),
    .average_temp_o (average_temp_o),
    .sensor_fault_o (sensor_fault_o),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  // Free-running clock, 2 ns period.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Weighted average, fault test and hysteresis decision for one scan.
  function automatic relay_result_t step_thermostat(input scan_t scan);
    relay_result_t res;
    int unsigned   used;
    longint        weight_sum;
    longint        weighted;
    longint        wgt;
    longint        fault_line;
    logic          fault;
    logic          may_turn_on;
    logic [TIME_W-1:0] elapsed;
    used = (cfg_count > TEMPS) ? TEMPS : cfg_count;
    weight_sum = 0;
    weighted = 0;
    for (int i = 0; i < used; i++) begin
      wgt = longint'(cfg_weights[BYTE_W*i +: BYTE_W]);
      weighted += longint'($signed(scan.temps[i])) * wgt;
      weight_sum += wgt;
    end
    if (weight_sum == 0) begin
      res.average = NO_WEIGHT_AVG;
      fault = 1'b1;
      may_turn_on = 1'b0;
    end else begin
      res.average = TEMP_W'(weighted / weight_sum);
      fault_line = FAULT_SIXTEENTHS * weight_sum;
      fault = weighted < fault_line;
      may_turn_on = weighted > fault_line;
    end
    elapsed = scan.stamp - last_switch;
    res.action = ACT_NONE;
    // A fault always forces the relay off and restarts the dwell time.
    if (fault || (relay_is_on && weight_sum != 0 &&
                  weighted >= 16 * longint'(cfg_high_thr) * weight_sum &&
                  elapsed >= cfg_min_on)) begin
      relay_is_on = 1'b0;
      last_switch = scan.stamp;
      res.action = ACT_OFF;
      relay_offs++;
    end else if (may_turn_on && !relay_is_on &&
                 weighted <= 16 * longint'(cfg_low_thr) * weight_sum &&
                 elapsed >= cfg_min_off) begin
      relay_is_on = 1'b1;
      last_switch = scan.stamp;
      res.action = ACT_ON;
      relay_ons++;
    end
    if (fault) faults_seen++;
    res.relay = relay_is_on;
    res.fault = fault;
    return res;
  endfunction

  // Request driver: records the expected result of every accepted scan.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall_o) begin
        awaited_results.push_back(step_thermostat(offered_scan));
        scans_accepted++;
      end
      if (!(in_valid && in_stall_o)) begin
        if (pending_scans.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          offered_scan = pending_scans.pop_front();
          in_valid  <= 1'b1;
          stamp_drv <= offered_scan.stamp;
          temps_drv <= offered_scan.temps;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    relay_result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall) begin
        results_seen++;
        if (awaited_results.size() == 0) begin
          if (mismatches < MAX_REPORTS)
            $display("unexpected result: relay %0b action %0d average %0d fault %0b",
                     relay_state_o, action_o, average_temp_o, sensor_fault_o);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          if (relay_state_o !== want.relay || action_o !== want.action ||
              average_temp_o !== want.average || sensor_fault_o !== want.fault) begin
            if (mismatches < MAX_REPORTS)
              $display({"result %0d differs: expected relay %0b action %0d average %0d ",
                        "fault %0b, got relay %0b action %0d average %0d fault %0b"},
                       results_seen, want.relay, want.action, want.average, want.fault,
                       relay_state_o, action_o, average_temp_o, sensor_fault_o);
            mismatches++;
          end
        end
      end
      out_stall <= hold_off || ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Watchdog on cycles without any accepted request.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall_o) || (out_valid_o && !out_stall) ||
        (cfg_valid && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no request accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Long receiver hold-off so that the block backs up and stalls its input.
  initial begin
    do @(negedge clk_i); while (scans_accepted < 150);
    hold_off = 1'b1;
    repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
    hold_off = 1'b0;
  end

  function automatic void queue_scan(input logic [TIME_W-1:0] stamp,
                                     input logic [TEMPS-1:0][TEMP_W-1:0] temps);
    scan_t scan;
    scan.stamp = stamp;
    scan.temps = temps;
    pending_scans.push_back(scan);
  endfunction

  function automatic logic [TEMPS-1:0][TEMP_W-1:0] uniform_temps(input int value);
    logic [TEMP_W-1:0] t;
    t = TEMP_W'(value);
    return {TEMPS{t}};
  endfunction

  // Reading scattered around a target, clamped to the sensor range.
  function automatic logic [TEMP_W-1:0] near_temp(input int target, input int spread);
    int v;
    v = target + int'($urandom_range(0, 2 * spread)) - spread;
    if (v > 2047) v = 2047;
    if (v < -2048) v = -2048;
    return TEMP_W'(v);
  endfunction

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DAT_W-1:0] data);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    case (idx)
      REG_LOW_THR:  cfg_low_thr  = data[THR_W-1:0];
      REG_HIGH_THR: cfg_high_thr = data[THR_W-1:0];
      REG_MIN_ON:   cfg_min_on   = data[SEC_W-1:0];
      REG_MIN_OFF:  cfg_min_off  = data[SEC_W-1:0];
      REG_WEIGHTS:  cfg_weights  = data;
      REG_COUNT:    cfg_count    = data[CNT_W-1:0];
      default: ;
    endcase
  endtask

  // Wait until every scan has been taken and every result has come back.
  task automatic drain();
    do @(negedge clk_i);
    while (pending_scans.size() != 0 || in_valid || awaited_results.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic configure(input logic signed [THR_W-1:0] low_deg,
                           input logic signed [THR_W-1:0] high_deg,
                           input logic [SEC_W-1:0] on_secs, input logic [SEC_W-1:0] off_secs,
                           input logic [WGT_W-1:0] weights, input logic [CNT_W-1:0] count);
    drain();
    write_reg(REG_LOW_THR, CFG_DAT_W'(low_deg));
    write_reg(REG_HIGH_THR, CFG_DAT_W'(high_deg));
    write_reg(REG_MIN_ON, CFG_DAT_W'(on_secs));
    write_reg(REG_MIN_OFF, CFG_DAT_W'(off_secs));
    write_reg(REG_WEIGHTS, weights);
    write_reg(REG_COUNT, CFG_DAT_W'(count));
    settings_used++;
    @(negedge clk_i);
  endtask

  function automatic logic [SEC_W-1:0] pick_dwell();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return '0;
    if (r < 75) return SEC_W'($urandom_range(1, 40));
    return SEC_W'($urandom_range(0, 65535));
  endfunction

  function automatic logic [WGT_W-1:0] pick_weights();
    logic [WGT_W-1:0] w;
    int r;
    for (int i = 0; i < TEMPS; i++) begin
      r = $urandom_range(0, 99);
      if (r < 15) w[BYTE_W*i +: BYTE_W] = '0;
      else if (r < 25) w[BYTE_W*i +: BYTE_W] = '1;
      else w[BYTE_W*i +: BYTE_W] = BYTE_W'($urandom_range(0, 255));
    end
    return w;
  endfunction

  // One random phase: new register setting, then scans mostly around the thresholds, some random or at fault level.
  task automatic random_phase(input int phase);
    logic signed [THR_W-1:0] low_deg;
    logic signed [THR_W-1:0] high_deg;
    logic [TEMPS-1:0][TEMP_W-1:0] temps;
    int dwell;
    int mode;
    int target;
    int r;
    if (phase == 1) begin
      configure(-8'sd55, 8'sd125, '0, '0, '1, 4'd8);
    end else if (phase == 2) begin
      configure(8'sd125, -8'sd55, '1, '1, pick_weights(), 4'd15);
    end else begin
      low_deg = THR_W'(int'($urandom_range(0, 180)) - 55);
      high_deg = (low_deg > 8'sd105) ? 8'sd125 : low_deg + THR_W'($urandom_range(0, 20));
      if ($urandom_range(0, 9) == 0) begin
        low_deg  = high_deg;
        high_deg = THR_W'(int'($urandom_range(0, 180)) - 55);
      end
      configure(low_deg, high_deg, pick_dwell(), pick_dwell(), pick_weights(),
                ($urandom_range(0, 9) < 7) ? CNT_W'($urandom_range(1, 8))
                                           : CNT_W'($urandom_range(0, 15)));
    end
    // Sender and receiver idling by phase, the last phases run without gaps.
    if (phase <= 2) begin
      send_idle_pct = 34;
      recv_idle_pct = 70;
    end else if (phase <= 4) begin
      send_idle_pct = 70;
      recv_idle_pct = 34;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    dwell = int'((cfg_min_on > cfg_min_off) ? cfg_min_on : cfg_min_off);
    scan_clock = $urandom;
    for (int k = 0; k < PHASE_SCANS; k++) begin
      r = $urandom_range(0, 99);
      if (r < 5) scan_clock = scan_clock + $urandom;
      else if (r < 80) scan_clock = scan_clock + $urandom_range(0, dwell / 3 + 2);
      else if (r < 95) scan_clock = scan_clock + $urandom_range(0, dwell * 2 + 4);
      mode = $urandom_range(0, 99);
      if (mode < 40) target = 16 * int'(cfg_low_thr) + int'($urandom_range(0, 48)) - 24;
      else if (mode < 80) target = 16 * int'(cfg_high_thr) + int'($urandom_range(0, 48)) - 24;
      else if (mode < 90) target = 0;
      else target = ($urandom_range(0, 1) == 0) ? -1600 : -2048;
      for (int i = 0; i < TEMPS; i++) begin
        if (mode >= 80 && mode < 90) temps[i] = TEMP_W'($urandom_range(0, 4095));
        else if (mode >= 90) temps[i] = near_temp(target, 4);
        else temps[i] = near_temp(target, 16);
      end
      queue_scan(scan_clock, temps);
    end
  endtask

  // Reset, directed scans, random phases and the final verdict.
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    send_idle_pct = 34;
    recv_idle_pct = 70;

    // Reset settings: turn-on, dwell hold, turn-off, faults and the -100 degree edge.
    queue_scan(32'd10, uniform_temps(0));
    queue_scan(32'd15, uniform_temps(2047));
    queue_scan(32'd25, uniform_temps(2047));
    queue_scan(32'd26, uniform_temps(-2048));
    queue_scan(32'd40, uniform_temps(-1600));
    queue_scan(32'd50, {4{12'h555, 12'hAAA}});
    queue_scan(32'd55, uniform_temps(160));
    queue_scan(32'd60, uniform_temps(160));
    queue_scan(32'd65, uniform_temps(48));
    queue_scan(32'd70, uniform_temps(48));
    // Time stamp wrap-around.
    queue_scan(32'hFFFF_FFFF, uniform_temps(2047));
    queue_scan(32'd5, uniform_temps(0));
    queue_scan(32'd9, uniform_temps(0));
    // Small negative average truncates toward zero.
    queue_scan(32'd9, {12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'h000, 12'hFFE,
                       12'hFFF});

    // All weights zero, then no sensors in use.
    configure(LOW_THR_RST, HIGH_THR_RST, MIN_ON_RST, MIN_OFF_RST, '0, COUNT_RST);
    queue_scan(32'd100, {4{12'h555, 12'hAAA}});
    configure(LOW_THR_RST, HIGH_THR_RST, MIN_ON_RST, MIN_OFF_RST, WEIGHTS_RST, 4'd0);
    queue_scan(32'd200, uniform_temps(0));

    // Sensor count above the number of inputs, distinct weights.
    configure(LOW_THR_RST, HIGH_THR_RST, MIN_ON_RST, MIN_OFF_RST,
              64'h0102_0408_1020_4080, 4'd15);
    queue_scan(32'd300, uniform_temps(0));
    queue_scan(32'd400, {12'h800, 12'h7FF, 12'h001, 12'hFFF, 12'h400, 12'hC00, 12'h0AA,
                         12'hF55});

    // Single sensor in use.
    configure(LOW_THR_RST, HIGH_THR_RST, MIN_ON_RST, MIN_OFF_RST, '1, 4'd1);
    queue_scan(32'd500, {{7{12'h800}}, 12'h7FF});

    // Threshold and dwell extremes.
    configure(-8'sd55, 8'sd125, '0, '0, '1, 4'd8);
    queue_scan(32'd600, uniform_temps(-880));
    queue_scan(32'd600, uniform_temps(2000));
    configure(8'sd125, -8'sd55, '1, '1, '1, 4'd8);
    queue_scan(32'd600 + 32'd65535, uniform_temps(2000));
    queue_scan(32'd600 + 32'd65536, uniform_temps(0));

    for (int p = 0; p < RANDOM_PHASES; p++) random_phase(p);

    drain();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (awaited_results.size() != 0)
      $display("%0d expected results never arrived", awaited_results.size());
    $display("Checked %0d results from %0d scans under %0d register settings.",
             results_seen, scans_accepted, settings_used);
    $display("Relay switched on %0d times and off %0d times; %0d scans reported a fault.",
             relay_ons, relay_offs, faults_seen);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
